/* design/fps_pkg.sv */
// shared types, constants and tables for the fisheye pixel to sphere point block
`timescale 1ns / 1ps
`default_nettype none
package fps_pkg;

  localparam int MAX_DIM    = 2048;
  localparam int COORD_W    = $clog2(MAX_DIM);
  localparam int DELTA_W    = COORD_W + 1;
  localparam int R2_W       = 2 * COORD_W + 1;
  localparam int SQ_RAD_W   = 2 * ((R2_W + 17) / 2);
  localparam int ROOT_W     = SQ_RAD_W / 2;
  localparam int SQ_REM_W   = ROOT_W + 2;
  localparam int SQRT_STEPS = ROOT_W;

  localparam int FOCAL_W    = 20;
  localparam int RADIUS_W   = 16;
  localparam int ANGLE_W    = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int COLOR_W    = 8;
  localparam int POINT_W    = 17;

  localparam int THETA_STEPS = ANGLE_W;
  localparam int CORDIC_STEPS = 24;
  localparam int CXY_W = 34;
  localparam int CZ_W  = 33;

  localparam int DEN_W      = ROOT_W + 8;
  localparam int QUOT_STEPS = 18;
  localparam int PROD_W     = 51;
  localparam int MAG_W      = PROD_W + 1;

  localparam logic [FOCAL_W-1:0]  FOCAL_RESET  = 20'd43732;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd256;
  localparam logic [ANGLE_W-1:0]  ANGLE_RESET  = 15'd25736;

  localparam logic signed [CXY_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [CZ_W-1:0]  HALF_PI_Q30 = 33'sd1686629713;
  localparam logic [ANGLE_W-1:0]      THETA_MAX   = 15'd32767;
  localparam int                      COORD_LIMIT = 65535;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FOCAL  = 3'd0,
    CFG_RADIUS = 3'd1,
    CFG_ANGLE  = 3'd2,
    CFG_CROW   = 3'd3,
    CFG_CCOL   = 3'd4
  } cfg_idx_t;

  // per item side data that travels along the whole chain
  typedef struct packed {
    logic                      vld;
    logic [COLOR_W-1:0]        red;
    logic [COLOR_W-1:0]        green;
    logic [COLOR_W-1:0]        blue;
    logic signed [DELTA_W-1:0] drow;
    logic signed [DELTA_W-1:0] dcol;
    logic [ROOT_W-1:0]         rq;
    logic                      tovf;
    logic                      upper;
    logic signed [POINT_W-1:0] pz;
    logic                      neg_x;
    logic                      neg_y;
    logic                      ovf_x;
    logic                      ovf_y;
  } side_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] v;
    unique case (i)
      5'd0:  v = 30'd843314856;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043836;
      5'd3:  v = 30'd133525158;
      5'd4:  v = 30'd67021686;
      5'd5:  v = 30'd33543515;
      5'd6:  v = 30'd16775850;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194282;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048575;
      5'd11: v = 30'd524287;
      5'd12: v = 30'd262143;
      5'd13: v = 30'd131071;
      5'd14: v = 30'd65535;
      5'd15: v = 30'd32767;
      5'd16: v = 30'd16383;
      5'd17: v = 30'd8191;
      5'd18: v = 30'd4095;
      5'd19: v = 30'd2047;
      5'd20: v = 30'd1023;
      5'd21: v = 30'd511;
      5'd22: v = 30'd255;
      5'd23: v = 30'd127;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* design/fps_in_if.sv */
// pixel input channel interface
`timescale 1ns / 1ps
`default_nettype none
interface fps_in_if import fps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] col;
  logic [COLOR_W-1:0] red_in;
  logic [COLOR_W-1:0] green_in;
  logic [COLOR_W-1:0] blue_in;
  modport source (output valid, row, col, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, row, col, red_in, green_in, blue_in, output ready);
endinterface
`default_nettype wire

/* design/fps_out_if.sv */
// sphere point output channel interface
`timescale 1ns / 1ps
`default_nettype none
interface fps_out_if import fps_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [POINT_W-1:0] point_x;
  logic signed [POINT_W-1:0] point_y;
  logic signed [POINT_W-1:0] point_z;
  logic [COLOR_W-1:0]        red_out;
  logic [COLOR_W-1:0]        green_out;
  logic [COLOR_W-1:0]        blue_out;
  modport source (output valid, point_x, point_y, point_z, red_out, green_out, blue_out,
                  input ready);
  modport sink   (input valid, point_x, point_y, point_z, red_out, green_out, blue_out,
                  output ready);
endinterface
`default_nettype wire

/* design/fps_cfg_if.sv */
// configuration write channel interface
`timescale 1ns / 1ps
`default_nettype none
interface fps_cfg_if import fps_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* design/fps_sqrt_cell.sv */
// one digit step of the pipelined integer square root
`timescale 1ns / 1ps
`default_nettype none
module fps_sqrt_cell import fps_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  side_t               side_i,
  input  logic [SQ_REM_W-1:0] rem_i,
  input  logic [ROOT_W-1:0]   root_i,
  input  logic [SQ_RAD_W-1:0] rad_i,
  output side_t               side_o,
  output logic [SQ_REM_W-1:0] rem_o,
  output logic [ROOT_W-1:0]   root_o,
  output logic [SQ_RAD_W-1:0] rad_o
);
  side_t               side_r;
  logic [SQ_REM_W-1:0] rem_r, rem_nxt;
  logic [ROOT_W-1:0]   root_r, root_nxt;
  logic [SQ_RAD_W-1:0] rad_r;
  logic [SQ_REM_W+1:0] cur, trial;

  always_comb begin
    cur   = {rem_i, rad_i[SQ_RAD_W-1 -: 2]};
    trial = {2'b00, root_i, 2'b01};
    if (cur >= trial) begin
      rem_nxt  = SQ_REM_W'(cur - trial);
      root_nxt = {root_i[ROOT_W-2:0], 1'b1};
    end else begin
      rem_nxt  = SQ_REM_W'(cur);
      root_nxt = {root_i[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r.vld <= 1'b0;
    end else if (en) begin
      side_r <= side_i;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      rad_r  <= {rad_i[SQ_RAD_W-3:0], 2'b00};
    end
  end

  assign side_o = side_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign rad_o  = rad_r;
endmodule
`default_nettype wire

/* design/fps_theta_cell.sv */
// one quotient bit of the angle division r / k
`timescale 1ns / 1ps
`default_nettype none
module fps_theta_cell import fps_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic [FOCAL_W-1:0] focal,
  input  side_t              side_i,
  input  logic [FOCAL_W-1:0] rem_i,
  input  logic [ANGLE_W-1:0] num_i,
  input  logic [ANGLE_W-1:0] q_i,
  output side_t              side_o,
  output logic [FOCAL_W-1:0] rem_o,
  output logic [ANGLE_W-1:0] num_o,
  output logic [ANGLE_W-1:0] q_o
);
  side_t              side_r;
  logic [FOCAL_W-1:0] rem_r, rem_nxt;
  logic [ANGLE_W-1:0] num_r, q_r;
  logic [FOCAL_W:0]   cur;
  logic               ge;

  always_comb begin
    cur     = {rem_i, num_i[ANGLE_W-1]};
    ge      = cur >= {1'b0, focal};
    rem_nxt = ge ? FOCAL_W'(cur - {1'b0, focal}) : FOCAL_W'(cur);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r.vld <= 1'b0;
    end else if (en) begin
      side_r <= side_i;
      rem_r  <= rem_nxt;
      num_r  <= {num_i[ANGLE_W-2:0], 1'b0};
      q_r    <= {q_i[ANGLE_W-2:0], ge};
    end
  end

  assign side_o = side_r;
  assign rem_o  = rem_r;
  assign num_o  = num_r;
  assign q_o    = q_r;
endmodule
`default_nettype wire

/* design/fps_cordic_cell.sv */
// one rotation step of the sine and cosine cordic
`timescale 1ns / 1ps
`default_nettype none
module fps_cordic_cell import fps_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic [4:0]              step,
  input  side_t                   side_i,
  input  logic signed [CXY_W-1:0] x_i,
  input  logic signed [CXY_W-1:0] y_i,
  input  logic signed [CZ_W-1:0]  z_i,
  output side_t                   side_o,
  output logic signed [CXY_W-1:0] x_o,
  output logic signed [CXY_W-1:0] y_o,
  output logic signed [CZ_W-1:0]  z_o
);
  side_t                   side_r;
  logic signed [CXY_W-1:0] x_r, y_r, x_nxt, y_nxt, dx, dy;
  logic signed [CZ_W-1:0]  z_r, z_nxt, at;

  always_comb begin
    dx = y_i >>> step;
    dy = x_i >>> step;
    at = CZ_W'(signed'({1'b0, atan_q30(step)}));
    if (!z_i[CZ_W-1]) begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - at;
    end else begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r.vld <= 1'b0;
    end else if (en) begin
      side_r <= side_i;
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
    end
  end

  assign side_o = side_r;
  assign x_o    = x_r;
  assign y_o    = y_r;
  assign z_o    = z_r;
endmodule
`default_nettype wire

/* design/fps_quot_cell.sv */
// one quotient bit of the rounded x and y divisions, both lanes
`timescale 1ns / 1ps
`default_nettype none
module fps_quot_cell import fps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  side_t                 side_i,
  input  logic [DEN_W-1:0]      rem_x_i,
  input  logic [DEN_W-1:0]      rem_y_i,
  input  logic [QUOT_STEPS-1:0] num_x_i,
  input  logic [QUOT_STEPS-1:0] num_y_i,
  input  logic [QUOT_STEPS-1:0] q_x_i,
  input  logic [QUOT_STEPS-1:0] q_y_i,
  output side_t                 side_o,
  output logic [DEN_W-1:0]      rem_x_o,
  output logic [DEN_W-1:0]      rem_y_o,
  output logic [QUOT_STEPS-1:0] num_x_o,
  output logic [QUOT_STEPS-1:0] num_y_o,
  output logic [QUOT_STEPS-1:0] q_x_o,
  output logic [QUOT_STEPS-1:0] q_y_o
);
  side_t                 side_r;
  logic [DEN_W-1:0]      rem_x_r, rem_y_r, rem_x_nxt, rem_y_nxt, den;
  logic [QUOT_STEPS-1:0] num_x_r, num_y_r, q_x_r, q_y_r;
  logic [DEN_W:0]        cur_x, cur_y;
  logic                  ge_x, ge_y;

  always_comb begin
    den       = {side_i.rq, 8'b0};
    cur_x     = {rem_x_i, num_x_i[QUOT_STEPS-1]};
    cur_y     = {rem_y_i, num_y_i[QUOT_STEPS-1]};
    ge_x      = cur_x >= {1'b0, den};
    ge_y      = cur_y >= {1'b0, den};
    rem_x_nxt = ge_x ? DEN_W'(cur_x - {1'b0, den}) : DEN_W'(cur_x);
    rem_y_nxt = ge_y ? DEN_W'(cur_y - {1'b0, den}) : DEN_W'(cur_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r.vld <= 1'b0;
    end else if (en) begin
      side_r  <= side_i;
      rem_x_r <= rem_x_nxt;
      rem_y_r <= rem_y_nxt;
      num_x_r <= {num_x_i[QUOT_STEPS-2:0], 1'b0};
      num_y_r <= {num_y_i[QUOT_STEPS-2:0], 1'b0};
      q_x_r   <= {q_x_i[QUOT_STEPS-2:0], ge_x};
      q_y_r   <= {q_y_i[QUOT_STEPS-2:0], ge_y};
    end
  end

  assign side_o  = side_r;
  assign rem_x_o = rem_x_r;
  assign rem_y_o = rem_y_r;
  assign num_x_o = num_x_r;
  assign num_y_o = num_y_r;
  assign q_x_o   = q_x_r;
  assign q_y_o   = q_y_r;
endmodule
`default_nettype wire

/* design/fisheye_pixel_to_sphere_point.sv */
// stages from an accepted pixel to its point: 1 entry, 20 sqrt, 1+15 angle divide,
// 1+24 cordic, 3 multiply, 18 divide and 1 output register
// throughput: one pixel per cycle; the whole chain holds while a point waits at the output
// pixels at or beyond the angle limit leave no point and just free their slot
// reset (rst_n low, synchronous): all slots empty, registers back to their defaults
`timescale 1ns / 1ps
`default_nettype none
module fisheye_pixel_to_sphere_point import fps_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  fps_in_if.sink       in_ch,
  fps_out_if.source    out_ch,
  fps_cfg_if.sink      cfg_ch
);
  // configuration registers
  logic [FOCAL_W-1:0]  focal_r;
  logic [RADIUS_W-1:0] radius_r;
  logic [ANGLE_W-1:0]  max_angle_r;
  logic [COORD_W-1:0]  crow_r, ccol_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_r     <= FOCAL_RESET;
      radius_r    <= RADIUS_RESET;
      max_angle_r <= ANGLE_RESET;
      crow_r      <= '0;
      ccol_r      <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_FOCAL:  focal_r     <= cfg_ch.data;
        CFG_RADIUS: radius_r    <= cfg_ch.data[RADIUS_W-1:0];
        CFG_ANGLE:  max_angle_r <= cfg_ch.data[ANGLE_W-1:0];
        CFG_CROW:   crow_r      <= cfg_ch.data[COORD_W-1:0];
        CFG_CCOL:   ccol_r      <= cfg_ch.data[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // whole chain advances unless a point is held at the output
  logic out_valid_r;
  logic en;
  assign en          = !(out_valid_r && !out_ch.ready);
  assign in_ch.ready = en;

  logic signed [POINT_W-1:0] rad_s;
  assign rad_s = signed'({1'b0, radius_r});

  // entry stage: offsets and squared distance
  side_t           s0_side_r, s0_nxt;
  logic [R2_W-1:0] s0_r2_r;
  logic signed [2*DELTA_W-1:0] sq_r2, sq_c2;

  always_comb begin
    s0_nxt       = '0;
    s0_nxt.vld   = in_ch.valid;
    s0_nxt.red   = in_ch.red_in;
    s0_nxt.green = in_ch.green_in;
    s0_nxt.blue  = in_ch.blue_in;
    s0_nxt.drow  = signed'({1'b0, in_ch.row}) - signed'({1'b0, crow_r});
    s0_nxt.dcol  = signed'({1'b0, in_ch.col}) - signed'({1'b0, ccol_r});
    sq_r2 = (2*DELTA_W)'(s0_nxt.drow) * (2*DELTA_W)'(s0_nxt.drow);
    sq_c2 = (2*DELTA_W)'(s0_nxt.dcol) * (2*DELTA_W)'(s0_nxt.dcol);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_side_r.vld <= 1'b0;
    end else if (en) begin
      s0_side_r <= s0_nxt;
      s0_r2_r   <= R2_W'(unsigned'(sq_r2) + unsigned'(sq_c2));
    end
  end

  // square root chain
  side_t               sq_s    [0:SQRT_STEPS];
  logic [SQ_REM_W-1:0] sq_rem  [0:SQRT_STEPS];
  logic [ROOT_W-1:0]   sq_root [0:SQRT_STEPS];
  logic [SQ_RAD_W-1:0] sq_rad  [0:SQRT_STEPS];

  assign sq_s[0]    = s0_side_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_rad[0]  = SQ_RAD_W'({s0_r2_r, 16'b0});

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    fps_sqrt_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .side_i(sq_s[i]), .rem_i(sq_rem[i]), .root_i(sq_root[i]), .rad_i(sq_rad[i]),
      .side_o(sq_s[i+1]), .rem_o(sq_rem[i+1]), .root_o(sq_root[i+1]), .rad_o(sq_rad[i+1])
    );
  end

  // angle divide setup: the top part of rq<<14 tells saturation at once
  side_t              t0_side_r, t0_nxt;
  logic [FOCAL_W-1:0] t0_rem_r;
  logic [ANGLE_W-1:0] t0_num_r;
  logic [ROOT_W-1:0]  rq_n;

  always_comb begin
    rq_n        = sq_root[SQRT_STEPS];
    t0_nxt      = sq_s[SQRT_STEPS];
    t0_nxt.rq   = rq_n;
    t0_nxt.tovf = (rq_n != '0) && (FOCAL_W'(rq_n[ROOT_W-1:1]) >= focal_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t0_side_r.vld <= 1'b0;
    end else if (en) begin
      t0_side_r <= t0_nxt;
      t0_rem_r  <= FOCAL_W'(rq_n[ROOT_W-1:1]);
      t0_num_r  <= {rq_n[0], 14'b0};
    end
  end

  side_t              th_s   [0:THETA_STEPS];
  logic [FOCAL_W-1:0] th_rem [0:THETA_STEPS];
  logic [ANGLE_W-1:0] th_num [0:THETA_STEPS];
  logic [ANGLE_W-1:0] th_q   [0:THETA_STEPS];

  assign th_s[0]   = t0_side_r;
  assign th_rem[0] = t0_rem_r;
  assign th_num[0] = t0_num_r;
  assign th_q[0]   = '0;

  for (genvar i = 0; i < THETA_STEPS; i++) begin : g_theta
    fps_theta_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .focal(focal_r),
      .side_i(th_s[i]), .rem_i(th_rem[i]), .num_i(th_num[i]), .q_i(th_q[i]),
      .side_o(th_s[i+1]), .rem_o(th_rem[i+1]), .num_o(th_num[i+1]), .q_o(th_q[i+1])
    );
  end

  // angle limit and cordic setup
  side_t                  c0_side_r, c0_nxt;
  logic signed [CZ_W-1:0] c0_z_r, angle, c0_z_nxt;
  logic [ANGLE_W-1:0]     theta;

  always_comb begin
    c0_nxt = th_s[THETA_STEPS];
    if (c0_nxt.tovf) begin
      theta = THETA_MAX;
    end else if (c0_nxt.rq == '0) begin
      theta = '0;
    end else begin
      theta = th_q[THETA_STEPS];
    end
    c0_nxt.vld   = c0_nxt.vld && (theta < max_angle_r);
    angle        = signed'(CZ_W'({theta, 16'b0}));
    c0_nxt.upper = angle > HALF_PI_Q30;
    c0_z_nxt     = c0_nxt.upper ? angle - HALF_PI_Q30 : angle;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c0_side_r.vld <= 1'b0;
    end else if (en) begin
      c0_side_r <= c0_nxt;
      c0_z_r    <= c0_z_nxt;
    end
  end

  side_t                   co_s [0:CORDIC_STEPS];
  logic signed [CXY_W-1:0] co_x [0:CORDIC_STEPS];
  logic signed [CXY_W-1:0] co_y [0:CORDIC_STEPS];
  logic signed [CZ_W-1:0]  co_z [0:CORDIC_STEPS];

  assign co_s[0] = c0_side_r;
  assign co_x[0] = CORDIC_GAIN;
  assign co_y[0] = '0;
  assign co_z[0] = c0_z_r;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    fps_cordic_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .step(5'(i)),
      .side_i(co_s[i]), .x_i(co_x[i]), .y_i(co_y[i]), .z_i(co_z[i]),
      .side_o(co_s[i+1]), .x_o(co_x[i+1]), .y_o(co_y[i+1]), .z_o(co_z[i+1])
    );
  end

  // first multiply stage: sine rounding, offsets times radius, radius times cosine
  side_t               m0_side_r;
  logic signed [20:0]  m0_s16_r;
  logic signed [29:0]  m0_ax_r, m0_ay_r;
  logic signed [51:0]  m0_zp_r;
  logic signed [CXY_W:0] s30, c30, xe, ye, s16w;
  logic signed [DELTA_W:0] ndrow;

  always_comb begin
    xe    = (CXY_W+1)'(co_x[CORDIC_STEPS]);
    ye    = (CXY_W+1)'(co_y[CORDIC_STEPS]);
    s30   = co_s[CORDIC_STEPS].upper ? xe : ye;
    c30   = co_s[CORDIC_STEPS].upper ? -ye : xe;
    s16w  = (s30 + (CXY_W+1)'(8192)) >>> 14;
    ndrow = -(DELTA_W+1)'(co_s[CORDIC_STEPS].drow);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m0_side_r.vld <= 1'b0;
    end else if (en) begin
      m0_side_r <= co_s[CORDIC_STEPS];
      m0_s16_r  <= s16w[20:0];
      m0_ax_r   <= 30'(ndrow) * 30'(rad_s);
      m0_ay_r   <= 30'(co_s[CORDIC_STEPS].dcol) * 30'(rad_s);
      m0_zp_r   <= 52'(c30) * 52'(rad_s);
    end
  end

  // second multiply stage and z rounding
  side_t                    m1_side_r, m1_nxt;
  logic signed [PROD_W-1:0] m1_px_r, m1_py_r;
  logic signed [51:0]       zsh;

  always_comb begin
    m1_nxt = m0_side_r;
    zsh    = (m0_zp_r + (52'sd1 <<< 29)) >>> 30;
    if (zsh > 52'(COORD_LIMIT)) begin
      m1_nxt.pz = POINT_W'(COORD_LIMIT);
    end else if (zsh < -52'(COORD_LIMIT)) begin
      m1_nxt.pz = -POINT_W'(COORD_LIMIT);
    end else begin
      m1_nxt.pz = zsh[POINT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_side_r.vld <= 1'b0;
    end else if (en) begin
      m1_side_r <= m1_nxt;
      m1_px_r   <= PROD_W'(m0_ax_r) * PROD_W'(m0_s16_r);
      m1_py_r   <= PROD_W'(m0_ay_r) * PROD_W'(m0_s16_r);
    end
  end

  // divide setup: magnitude plus half the divisor, overflow seen from the top bits
  side_t              m2_side_r, m2_nxt;
  logic [DEN_W-1:0]   m2_rem_x_r, m2_rem_y_r;
  logic [QUOT_STEPS-1:0] m2_num_x_r, m2_num_y_r;
  logic signed [MAG_W-1:0] pwx, pwy;
  logic [MAG_W-1:0]   mag_x, mag_y, half;
  logic [MAG_W-QUOT_STEPS-1:0] den_w;

  always_comb begin
    m2_nxt       = m1_side_r;
    pwx          = MAG_W'(m1_px_r);
    pwy          = MAG_W'(m1_py_r);
    m2_nxt.neg_x = pwx[MAG_W-1];
    m2_nxt.neg_y = pwy[MAG_W-1];
    half         = MAG_W'({m1_side_r.rq, 7'b0});
    mag_x        = (m2_nxt.neg_x ? unsigned'(-pwx) : unsigned'(pwx)) + half;
    mag_y        = (m2_nxt.neg_y ? unsigned'(-pwy) : unsigned'(pwy)) + half;
    den_w        = (MAG_W-QUOT_STEPS)'({m1_side_r.rq, 8'b0});
    m2_nxt.ovf_x = mag_x[MAG_W-1:QUOT_STEPS] >= den_w;
    m2_nxt.ovf_y = mag_y[MAG_W-1:QUOT_STEPS] >= den_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_side_r.vld <= 1'b0;
    end else if (en) begin
      m2_side_r  <= m2_nxt;
      m2_rem_x_r <= mag_x[QUOT_STEPS+DEN_W-1:QUOT_STEPS];
      m2_rem_y_r <= mag_y[QUOT_STEPS+DEN_W-1:QUOT_STEPS];
      m2_num_x_r <= mag_x[QUOT_STEPS-1:0];
      m2_num_y_r <= mag_y[QUOT_STEPS-1:0];
    end
  end

  side_t                 qu_s     [0:QUOT_STEPS];
  logic [DEN_W-1:0]      qu_rem_x [0:QUOT_STEPS];
  logic [DEN_W-1:0]      qu_rem_y [0:QUOT_STEPS];
  logic [QUOT_STEPS-1:0] qu_num_x [0:QUOT_STEPS];
  logic [QUOT_STEPS-1:0] qu_num_y [0:QUOT_STEPS];
  logic [QUOT_STEPS-1:0] qu_q_x   [0:QUOT_STEPS];
  logic [QUOT_STEPS-1:0] qu_q_y   [0:QUOT_STEPS];

  assign qu_s[0]     = m2_side_r;
  assign qu_rem_x[0] = m2_rem_x_r;
  assign qu_rem_y[0] = m2_rem_y_r;
  assign qu_num_x[0] = m2_num_x_r;
  assign qu_num_y[0] = m2_num_y_r;
  assign qu_q_x[0]   = '0;
  assign qu_q_y[0]   = '0;

  for (genvar i = 0; i < QUOT_STEPS; i++) begin : g_quot
    fps_quot_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .side_i(qu_s[i]),
      .rem_x_i(qu_rem_x[i]), .rem_y_i(qu_rem_y[i]),
      .num_x_i(qu_num_x[i]), .num_y_i(qu_num_y[i]),
      .q_x_i(qu_q_x[i]), .q_y_i(qu_q_y[i]),
      .side_o(qu_s[i+1]),
      .rem_x_o(qu_rem_x[i+1]), .rem_y_o(qu_rem_y[i+1]),
      .num_x_o(qu_num_x[i+1]), .num_y_o(qu_num_y[i+1]),
      .q_x_o(qu_q_x[i+1]), .q_y_o(qu_q_y[i+1])
    );
  end

  // output register: saturate, restore sign, centre pixel gives zero
  side_t                     fs;
  logic signed [POINT_W-1:0] fx, fy, mx, my;
  logic signed [POINT_W-1:0] px_r, py_r, pz_r;
  logic [COLOR_W-1:0]        red_r, green_r, blue_r;
  logic [QUOT_STEPS-1:0]     qx, qy;

  always_comb begin
    fs = qu_s[QUOT_STEPS];
    qx = qu_q_x[QUOT_STEPS];
    qy = qu_q_y[QUOT_STEPS];
    mx = (fs.ovf_x || qx[QUOT_STEPS-1:16] != '0) ? POINT_W'(COORD_LIMIT)
                                                : signed'({1'b0, qx[15:0]});
    my = (fs.ovf_y || qy[QUOT_STEPS-1:16] != '0) ? POINT_W'(COORD_LIMIT)
                                                : signed'({1'b0, qy[15:0]});
    if (fs.rq == '0) begin
      fx = '0;
      fy = '0;
    end else begin
      fx = fs.neg_x ? -mx : mx;
      fy = fs.neg_y ? -my : my;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= fs.vld;
      px_r        <= fx;
      py_r        <= fy;
      pz_r        <= fs.pz;
      red_r       <= fs.red;
      green_r     <= fs.green;
      blue_r      <= fs.blue;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.point_x   = px_r;
  assign out_ch.point_y   = py_r;
  assign out_ch.point_z   = pz_r;
  assign out_ch.red_out   = red_r;
  assign out_ch.green_out = green_r;
  assign out_ch.blue_out  = blue_r;
endmodule
`default_nettype wire

/* tb/fisheye_pixel_to_sphere_point_tb.sv */
// self-checking testbench for the fisheye pixel to sphere point block
`timescale 1ns / 1ps
module fisheye_pixel_to_sphere_point_tb;
  import fps_pkg::*;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic signed [POINT_W-1:0] x;
    logic signed [POINT_W-1:0] y;
    logic signed [POINT_W-1:0] z;
    logic [COLOR_W-1:0]        red;
    logic [COLOR_W-1:0]        green;
    logic [COLOR_W-1:0]        blue;
  } point_t;

  localparam int SETTLE_CYCLES = 100;
  localparam int STALL_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 300;

  logic clk;
  logic rst_n;

  fps_in_if  in_ch ();
  fps_out_if out_ch ();
  fps_cfg_if cfg_ch ();

  fisheye_pixel_to_sphere_point dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // local copy of the register file
  logic [FOCAL_W-1:0]  focal_q;
  logic [RADIUS_W-1:0] radius_q;
  logic [ANGLE_W-1:0]  angle_lim_q;
  logic [COORD_W-1:0]  crow_q;
  logic [COORD_W-1:0]  ccol_q;

  pixel_t pixel_queue[$];
  point_t point_queue[$];
  pixel_t cur_pixel;

  int errors;
  int pixels_sent;
  int points_seen;
  int send_gap;
  int recv_gap;
  int hold_left;
  int quiet_cycles;
  logic hold_go;
  logic hold_seen;
  logic burst_mode;

  longint arctan_tbl [CORDIC_STEPS] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767, 16383, 8191,
    4095, 2047, 1023, 511, 255, 127
  };

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint round_div(input longint num, input longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint clamp_coord(input longint v);
    if (v > COORD_LIMIT) return COORD_LIMIT;
    if (v < -COORD_LIMIT) return -COORD_LIMIT;
    return v;
  endfunction

  // returns 1 when the pixel lies inside the view limit and fills in its point
  function automatic bit project_pixel(input pixel_t p, output point_t q);
    longint drow, dcol, r2, rq, theta, angle, x, y, z, dx, dy;
    longint s30, c30, s16, rad, den, px, py, pz;
    bit upper;
    drow = longint'(p.row) - longint'(crow_q);
    dcol = longint'(p.col) - longint'(ccol_q);
    r2 = drow * drow + dcol * dcol;
    rq = longint'(int_sqrt(r2 << 16));
    if (focal_q == 0) theta = (rq == 0) ? 0 : 32767;
    else theta = (rq << 14) / longint'(focal_q);
    if (theta > 32767) theta = 32767;
    q = '0;
    if (theta >= longint'(angle_lim_q)) return 1'b0;
    angle = theta << 16;
    upper = angle > 64'sd1686629713;
    x = 652032874;
    y = 0;
    z = upper ? angle - 64'sd1686629713 : angle;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - arctan_tbl[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + arctan_tbl[i];
      end
    end
    s30 = upper ? x : y;
    c30 = upper ? -y : x;
    s16 = (s30 + (64'sd1 << 13)) >>> 14;
    rad = longint'(radius_q);
    pz = (rad * c30 + (64'sd1 << 29)) >>> 30;
    if (rq == 0) begin
      px = 0;
      py = 0;
    end else begin
      den = rq * 256;
      px = round_div(-drow * rad * s16, den);
      py = round_div(dcol * rad * s16, den);
    end
    q.x = POINT_W'(clamp_coord(px));
    q.y = POINT_W'(clamp_coord(py));
    q.z = POINT_W'(clamp_coord(pz));
    q.red = p.red;
    q.green = p.green;
    q.blue = p.blue;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // pixel driver
  always @(posedge clk) begin
    pixel_t p;
    point_t q;
    int g;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap <= 0;
    end else if (in_ch.valid && in_ch.ready) begin
      pixels_sent++;
      if (project_pixel(cur_pixel, q)) point_queue = {point_queue, q};
      g = (burst_mode || (pixels_sent % 90 >= 45)) ? 0 : $urandom_range(0, 14);
      if (g == 0 && pixel_queue.size() > 0) begin
        p = pixel_queue.pop_front();
        cur_pixel = p;
        in_ch.row <= p.row;
        in_ch.col <= p.col;
        in_ch.red_in <= p.red;
        in_ch.green_in <= p.green;
        in_ch.blue_in <= p.blue;
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
      send_gap <= g;
    end else if (!in_ch.valid) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
      end else if (pixel_queue.size() > 0) begin
        p = pixel_queue.pop_front();
        cur_pixel = p;
        in_ch.row <= p.row;
        in_ch.col <= p.col;
        in_ch.red_in <= p.red;
        in_ch.green_in <= p.green;
        in_ch.blue_in <= p.blue;
        in_ch.valid <= 1'b1;
      end
    end
  end

  // point monitor and receiver stalls
  always @(posedge clk) begin
    point_t want;
    int g;
    int h;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_gap <= 0;
      hold_left <= 0;
      hold_seen <= 1'b0;
    end else begin
      g = recv_gap;
      h = hold_left;
      if (hold_go && !hold_seen) begin
        h = HOLD_CYCLES;
        hold_seen <= 1'b1;
      end else if (h > 0) begin
        h--;
      end
      if (out_ch.valid && out_ch.ready) begin
        points_seen++;
        if (point_queue.size() == 0) begin
          $display("unexpected point at %0t", $realtime);
          errors++;
        end else begin
          want = point_queue.pop_front();
          if (out_ch.point_x !== want.x) report_mismatch("point_x", out_ch.point_x, want.x);
          if (out_ch.point_y !== want.y) report_mismatch("point_y", out_ch.point_y, want.y);
          if (out_ch.point_z !== want.z) report_mismatch("point_z", out_ch.point_z, want.z);
          if (out_ch.red_out !== want.red) report_mismatch("red", out_ch.red_out, want.red);
          if (out_ch.green_out !== want.green)
            report_mismatch("green", out_ch.green_out, want.green);
          if (out_ch.blue_out !== want.blue)
            report_mismatch("blue", out_ch.blue_out, want.blue);
        end
        g = (points_seen % 70 >= 35) ? 0 : $urandom_range(0, 14);
      end else if (g > 0) begin
        g--;
      end
      recv_gap <= g;
      hold_left <= h;
      out_ch.ready <= (g == 0) && (h == 0);
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_FOCAL:  focal_q = val[FOCAL_W-1:0];
      CFG_RADIUS: radius_q = val[RADIUS_W-1:0];
      CFG_ANGLE:  angle_lim_q = val[ANGLE_W-1:0];
      CFG_CROW:   crow_q = val[COORD_W-1:0];
      CFG_CCOL:   ccol_q = val[COORD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_view(input int k, input int rad, input int lim, input int cr, input int cc);
    write_reg(CFG_FOCAL, CFG_DATA_W'(k));
    write_reg(CFG_RADIUS, CFG_DATA_W'(rad));
    write_reg(CFG_ANGLE, CFG_DATA_W'(lim));
    write_reg(CFG_CROW, CFG_DATA_W'(cr));
    write_reg(CFG_CCOL, CFG_DATA_W'(cc));
  endtask

  task automatic queue_pixel(input int r, input int c);
    pixel_t p;
    p.row = r[COORD_W-1:0];
    p.col = c[COORD_W-1:0];
    p.red = COLOR_W'($urandom);
    p.green = COLOR_W'($urandom);
    p.blue = COLOR_W'($urandom);
    @(negedge clk);
    pixel_queue = {pixel_queue, p};
  endtask

  // waits until every pixel is out and every point has arrived, then lets the pipe drain
  task automatic drain();
    while (pixel_queue.size() > 0 || in_ch.valid || point_queue.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // pixels mostly inside the view cone around the centre, some anywhere in the frame
  task automatic queue_random(input int n);
    int span;
    span = int'(focal_q) / 128;
    if (span < 2) span = 2;
    if (span > 1023) span = 1023;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0)
        queue_pixel($urandom_range(0, 2047), $urandom_range(0, 2047));
      else
        queue_pixel(int'(crow_q) + $urandom_range(0, 2 * span) - span,
                    int'(ccol_q) + $urandom_range(0, 2 * span) - span);
    end
  endtask

  initial begin
    pixel_t p;
    errors = 0;
    pixels_sent = 0;
    points_seen = 0;
    quiet_cycles = 0;
    hold_go = 1'b0;
    burst_mode = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.row = '0;
    in_ch.col = '0;
    in_ch.red_in = '0;
    in_ch.green_in = '0;
    in_ch.blue_in = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_FOCAL;
    cfg_ch.data = '0;
    focal_q = FOCAL_RESET;
    radius_q = RADIUS_RESET;
    angle_lim_q = ANGLE_RESET;
    crow_q = '0;
    ccol_q = '0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // defaults: corners, centre, colour extremes
    p = '{row: 11'd0, col: 11'd0, red: 8'hff, green: 8'h00, blue: 8'hff};
    @(negedge clk);
    pixel_queue = {pixel_queue, p};
    p = '{row: 11'd2047, col: 11'd2047, red: 8'h00, green: 8'hff, blue: 8'h00};
    pixel_queue = {pixel_queue, p};
    queue_pixel(0, 2047);
    queue_pixel(2047, 0);
    queue_pixel(100, 150);
    queue_pixel(267, 0);
    queue_pixel(0, 268);
    drain();

    // centre in the middle, extreme radius and zero focal scale
    set_view(0, 65535, 25736, 1024, 1024);
    queue_pixel(1024, 1024);
    queue_pixel(1025, 1024);
    queue_pixel(0, 0);
    drain();
    // widest focal scale, smallest radius
    set_view(1048575, 1, 25736, 2047, 2047);
    queue_pixel(2047, 2047);
    queue_pixel(0, 0);
    queue_pixel(2047, 0);
    queue_pixel(1000, 1500);
    drain();
    // zero limit: nothing passes
    set_view(43732, 256, 0, 0, 0);
    queue_pixel(0, 0);
    queue_pixel(5, 5);
    drain();
    // narrow cone, large radius so the side coordinates saturate
    set_view(2560, 65535, 25736, 512, 700);
    queue_pixel(512, 700);
    queue_pixel(512 + 35, 700);
    queue_pixel(512, 700 - 38);
    queue_pixel(512 - 20, 700 + 25);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      set_view(($urandom_range(0, 9) == 0) ? $urandom_range(0, 1048575)
                                            : $urandom_range(512, 256 * 500),
               ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535)
                                           : $urandom_range(1, 4096),
               ($urandom_range(0, 4) == 0) ? $urandom_range(0, 25736)
                                           : $urandom_range(20000, 25736),
               $urandom_range(0, 2047), $urandom_range(0, 2047));
      if (ph == 4) begin
        // wide cone so most items pass and the chain really fills
        write_reg(CFG_FOCAL, CFG_DATA_W'(FOCAL_RESET));
        write_reg(CFG_ANGLE, CFG_DATA_W'(ANGLE_RESET));
        // receiver holds off while the sender keeps pushing
        burst_mode = 1'b1;
        @(posedge clk);
        hold_go <= 1'b1;
      end
      queue_random((ph == 4) ? 150 : 45);
      drain();
      burst_mode = 1'b0;
    end

    $display("covered %0d pixels and %0d points over 15 register settings", pixels_sent,
             points_seen);
    $display("stress included a long output hold-off and full-drain pauses");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
